// File: sv/triggered_capture_and_route_macros.svh
// Assertion macros for the triggered capture and route block.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef TRIGGERED_CAPTURE_AND_ROUTE_MACROS_SVH
`define TRIGGERED_CAPTURE_AND_ROUTE_MACROS_SVH

// Clocked check, off while reset is asserted.
`define TCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/tcr_pkg.sv
// Package for the triggered capture and route block: widths, defaults, codes.
// No dependencies.
`default_nettype none

package tcr_pkg;

  localparam int unsigned CAPTURE_DEPTH_DEF = 1024;
  localparam int unsigned DECIMATION_DEF    = 10;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned PWM_W      = 16;
  localparam int unsigned SLOT_OUT_W = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PWM_SHIFT  = 12;
  localparam int unsigned PROD_W     = SAMPLE_W + PWM_W;

  localparam logic [SAMPLE_W-1:0] MID_SCALE    = 12'h800;
  localparam logic [SAMPLE_W-1:0] PREV_A_RESET = 12'hfff;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_APP_SELECT = 2'd0,
    CFG_RATE_MODE  = 2'd1,
    CFG_PWM_PERIOD = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RATE_FULL  = 2'd0,
    RATE_DECIM = 2'd1,
    RATE_PWM   = 2'd2
  } rate_mode_e;

  typedef struct packed {
    logic                  dac_write;
    logic [SAMPLE_W-1:0]   dac_a;
    logic [SAMPLE_W-1:0]   dac_b;
    logic [PWM_W-1:0]      pwm_compare;
    logic [SLOT_OUT_W-1:0] slot_written;
    logic                  armed;
  } result_t;

endpackage

`default_nettype wire

// File: sv/triggered_capture_and_route.sv
// Triggered capture and route: top level with capture memories and output skid.
// Depends on tcr_pkg and triggered_capture_and_route_macros.svh.
//
// Usage:
//   Input channel: one beat carries a sample pair (sample_a_i, sample_b_i),
//   taken when in_valid_i is high and in_stall_o is low. The pair is written
//   into both capture memories at the current slot on every beat.
//   Output channel: at most one result beat per input beat, in order, taken
//   when out_valid_o is high and out_stall_i is low. In decimate mode only
//   every DECIMATION-th beat yields a result.
//   Config channel: cfg_index_i selects app_select, rate_mode or pwm_period;
//   cfg_ready_o is always high. Write only while the block is idle.
//   Each result is registered in the output register, or in the skid entry.
//   Throughput: one beat per cycle while in_stall_o is low; the pair write
//   into the capture memories and the single 12x16 compare multiply both
//   fit in that cycle. Stall: the output register is backed by one skid entry.
//   in_stall_o is the registered skid-occupied flag, so a receiver stall reaches
//   the input once a result waits in the skid entry; no beat is ever dropped.
//   Reset: counters, slot, config, valid flags clear; prev sample reads 0xfff.
//   No clearing pass: the capture memories hold garbage until written.
`default_nettype none

module triggered_capture_and_route
  import tcr_pkg::*;
#(
  parameter int unsigned CAPTURE_DEPTH = CAPTURE_DEPTH_DEF,
  parameter int unsigned DECIMATION    = DECIMATION_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // sample input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [SAMPLE_W-1:0]   sample_a_i,
  input  wire logic [SAMPLE_W-1:0]   sample_b_i,
  // result output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       dac_write_o,
  output logic [SAMPLE_W-1:0]        dac_a_o,
  output logic [SAMPLE_W-1:0]        dac_b_o,
  output logic [PWM_W-1:0]           pwm_compare_o,
  output logic [SLOT_OUT_W-1:0]      slot_written_o,
  output logic                       armed_o
);

  localparam int unsigned SlotW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
  localparam int unsigned DecW  = $clog2(DECIMATION + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic             app_select_q;
  logic [1:0]       rate_mode_q;
  logic [PWM_W-1:0] pwm_period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      app_select_q <= 1'b0;
      rate_mode_q  <= RATE_FULL;
      pwm_period_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_APP_SELECT: app_select_q <= cfg_data_i[0];
        CFG_RATE_MODE:  rate_mode_q  <= cfg_data_i[1:0];
        CFG_PWM_PERIOD: pwm_period_q <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Capture state
  // ---------------------------------------------------------------------------
  logic                in_acc;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [SlotW:0]      slot_inc;
  logic [SAMPLE_W-1:0] prev_a_q;
  logic [31:0]         wrap_cnt_q, wrap_cnt_d;
  logic [31:0]         sample_cnt_q;
  logic [DecW-1:0]     dec_q, dec_d, dec_inc;
  logic                dec_hit;
  logic                trigger;

  // Capture memories, write only; readback lives outside this block.
  logic [SAMPLE_W-1:0] cap_mem_a_q [CAPTURE_DEPTH];
  logic [SAMPLE_W-1:0] cap_mem_b_q [CAPTURE_DEPTH];

  assign in_acc = in_valid_i && !in_stall_o;

  // Rising crossing of mid-scale on channel one.
  assign trigger  = (sample_a_i >= MID_SCALE) && (prev_a_q < MID_SCALE);
  assign slot_inc = {1'b0, slot_q} + 1'b1;

  always_comb begin
    wrap_cnt_d = wrap_cnt_q;
    if (slot_q == '0) begin
      // armed: start a pass on trigger
      slot_d = trigger ? SlotW'(1) : '0;
    end else if (slot_inc == (SlotW+1)'(CAPTURE_DEPTH)) begin
      slot_d     = '0;                 // wrap re-arms
      wrap_cnt_d = wrap_cnt_q + 32'd1;
    end else begin
      slot_d = slot_inc[SlotW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cap_mem_a_q[slot_q] <= sample_a_i;
      cap_mem_b_q[slot_q] <= sample_b_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Routing
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0]     pwm_prod;
  logic [PWM_W-1:0]      pwm_scaled;
  logic [SlotW+9:0]      slot_ext;
  logic                  decimating;
  logic                  produce;
  result_t               res_new;

  assign pwm_prod   = PROD_W'(sample_a_i) * PROD_W'(pwm_period_q);
  assign pwm_scaled = pwm_prod[PROD_W-1:PWM_SHIFT];
  assign slot_ext   = {10'b0, slot_q};

  assign decimating = !app_select_q && (rate_mode_q == RATE_DECIM);
  assign dec_inc    = dec_q + 1'b1;
  assign dec_hit    = dec_inc >= DecW'(DECIMATION);
  assign dec_d      = dec_hit ? '0 : dec_inc;
  assign produce    = !decimating || dec_hit;

  always_comb begin
    res_new.slot_written = slot_ext[SLOT_OUT_W-1:0];
    res_new.armed        = (slot_d == '0);
    if (app_select_q) begin
      res_new.dac_write   = 1'b0;
      res_new.dac_a       = '0;
      res_new.dac_b       = '0;
      res_new.pwm_compare = pwm_scaled;
    end else begin
      res_new.dac_write   = 1'b1;
      res_new.dac_a       = sample_a_i;
      res_new.dac_b       = sample_b_i;
      res_new.pwm_compare = (rate_mode_q == RATE_PWM) ? pwm_scaled : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q       <= '0;
      prev_a_q     <= PREV_A_RESET;
      wrap_cnt_q   <= '0;
      sample_cnt_q <= '0;
      dec_q        <= '0;
    end else if (in_acc) begin
      slot_q       <= slot_d;
      prev_a_q     <= sample_a_i;
      wrap_cnt_q   <= wrap_cnt_d;
      sample_cnt_q <= sample_cnt_q + 32'd1;
      if (decimating) begin
        dec_q <= dec_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with one skid entry
  // ---------------------------------------------------------------------------
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_fire, out_free, new_res;

  assign out_fire   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || out_fire;
  assign new_res    = in_acc && produce;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // input is stalled; drain skid first
      if (out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (new_res) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (new_res) begin
      if (out_free) begin
        out_q <= res_new;
      end else begin
        skid_q <= res_new;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dac_write_o    = out_q.dac_write;
  assign dac_a_o        = out_q.dac_a;
  assign dac_b_o        = out_q.dac_b;
  assign pwm_compare_o  = out_q.pwm_compare;
  assign slot_written_o = out_q.slot_written;
  assign armed_o        = out_q.armed;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "triggered_capture_and_route_macros.svh"

  `TCR_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with empty output")
  `TCR_ASSERT(a_dec_range, dec_q < DecW'(DECIMATION), "decimation counter out of range")
  `TCR_ASSERT(a_slot_step, (in_acc && slot_q != '0) |=> (slot_q == '0) || (slot_q == $past(slot_q) + 1'b1), "slot did not advance by one")
  `TCR_ASSERT(a_pwm_result, (in_acc && app_select_q) |=> out_valid_q, "PWM beat produced no result")

endmodule

`default_nettype wire
